/* hw/rtl/tabular_q_learning_update_defines.svh */
// Assertion macros for the Q-learning update block.
// Used by tql_ctrl, tql_datapath and tabular_q_learning_update; needs clock and reset in scope.
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TQL_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tql assertion failed");
`define TQL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tql assertion failed");
`else
`define TQL_ASSERT(lbl, ante, cons)
`define TQL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/tql_pkg.sv */
// Package for the Q-learning update block: sizes, fixed-point formats, register
// indexes and the transaction and controller command types. No dependencies.
package tql_pkg;

   localparam int NUM_STATES  = 256;
   localparam int NUM_ACTIONS = 8;
   localparam int STATE_W     = $clog2(NUM_STATES);
   localparam int ACT_W       = $clog2(NUM_ACTIONS);
   localparam int ENTRY_W     = STATE_W + ACT_W;
   localparam int NUM_ENTRIES = NUM_STATES * NUM_ACTIONS;
   localparam int CNT_W       = ACT_W + 1;

   localparam int Q_W     = 24;
   localparam int FRAC_W  = 16;
   localparam int ALPHA_W = 16;
   localparam int GAMMA_W = 17;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 17'd58982;
   localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 17'd65536;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = GAMMA_W;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT      = 1'd1;

   typedef struct packed {
      logic [7:0]            state_index;
      logic [2:0]            action_taken;
      logic signed [Q_W-1:0] reward;
      logic [7:0]            next_state_index;
      logic [3:0]            next_action_count;
      logic                  terminal;
   } tql_req_type;

   typedef struct packed {
      logic [2:0]            greedy_action;
      logic signed [Q_W-1:0] best_next_q;
      logic signed [Q_W-1:0] updated_q;
   } tql_rsp_type;

   typedef struct packed {
      logic             load;
      logic             clear;
      logic             scan_rd;
      logic [ACT_W-1:0] scan_idx;
      logic             cur_rd;
      logic             gmul;
      logic             target;
      logic             amul;
      logic             update;
   } tql_cmd_type;

   typedef struct packed {
      logic clear_last;
   } tql_status_type;

endpackage

/* hw/rtl/tabular_q_learning_update.sv */
// Top level of the tabular Q-learning update block.
// Depends on tql_pkg, tql_ctrl, tql_datapath and tabular_q_learning_update_defines.svh.
//
// Usage notes
//  - Transactions are offered on req_data with start; one is taken at a clock
//    edge where start is high and busy is low.
//  - Each transaction gives exactly one result on rsp_data, shown for a single
//    cycle with rsp_valid high. The receiver cannot stall; it must take it then.
//  - Terminal transactions skip the scan; others first scan N actions, N being
//    the normalised next-state action count (1..8). busy stays high until the
//    result strobe and drops in the strobe cycle, so a new transaction may be
//    started then; none is taken while one is still in flight.
//  - The steps follow the Q table: one entry read per cycle for the greedy
//    scan, then a read, two multiply stages with the target sum between them, and a write back.
//  - Reset (synchronous, active high) loads the default alpha and gamma and
//    then sweeps the 2048-entry table to zero, one entry a cycle; busy stays
//    high until the sweep ends. CSR writes are taken while reset is low and
//    land at once, but should only be issued while no transaction is in flight.
`include "tabular_q_learning_update_defines.svh"
module tabular_q_learning_update (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tql_pkg::tql_req_type           req_data,
   output logic                           rsp_valid,
   output tql_pkg::tql_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [tql_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tql_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tql_pkg::*;

   tql_cmd_type    cmd;
   tql_status_type status;

   // sequencing: clear sweep, scan, read-modify-write
   tql_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table, arithmetic and CSRs
   tql_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result only appears once the controller is back in idle
   `TQL_ASSERT(a_rsp_when_idle, rsp_valid, !busy)

endmodule

/* hw/rtl/tql_ctrl.sv */
// Controller state machine of the Q-learning update block.
// Depends on tql_pkg and tabular_q_learning_update_defines.svh.
`include "tabular_q_learning_update_defines.svh"
module tql_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tql_pkg::tql_req_type    req_data,
   input  tql_pkg::tql_status_type status,
   output tql_pkg::tql_cmd_type    cmd,
   output logic                    busy
);
   import tql_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_CUR_RD = 8'b0000_1000,
      ST_GMUL   = 8'b0001_0000,
      ST_TARGET = 8'b0010_0000,
      ST_AMUL   = 8'b0100_0000,
      ST_UPDATE = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [ACT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             scan_last;

   // zero means one action, anything above the table width is clipped
   function automatic logic [CNT_W-1:0] norm_count(input logic [3:0] c);
      logic [CNT_W-1:0] r;
      if (c == 4'd0) begin
         r = CNT_W'(1);
      end else if (int'(c) > NUM_ACTIONS) begin
         r = CNT_W'(NUM_ACTIONS);
      end else begin
         r = CNT_W'(c);
      end
      return r;
   endfunction

   assign scan_last = ({1'b0, scan_idx_ff} == (count_ff - CNT_W'(1)));
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      count_in    = count_ff;
      cmd         = '0;
      cmd.scan_idx = scan_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               count_in    = norm_count(req_data.next_action_count);
               scan_idx_in = '0;
               state_in    = req_data.terminal ? ST_CUR_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (scan_last) begin
               state_in = ST_CUR_RD;
            end else begin
               scan_idx_in = scan_idx_ff + ACT_W'(1);
            end
         end
         ST_CUR_RD: begin
            cmd.cur_rd = 1'b1;
            state_in   = ST_GMUL;
         end
         ST_GMUL: begin
            cmd.gmul = 1'b1;
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.target = 1'b1;
            state_in   = ST_AMUL;
         end
         ST_AMUL: begin
            cmd.amul = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         scan_idx_ff <= '0;
         count_ff    <= CNT_W'(1);
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         count_ff    <= count_in;
      end
   end

   `TQL_ASSERT_NEXT(a_accept_leaves_idle, start && state_ff == ST_IDLE,
                    state_ff == ST_SCAN || state_ff == ST_CUR_RD)
   `TQL_ASSERT(a_scan_in_range, state_ff == ST_SCAN, {1'b0, scan_idx_ff} < count_ff)
   `TQL_ASSERT_NEXT(a_update_then_idle, state_ff == ST_UPDATE, state_ff == ST_IDLE)

endmodule

/* hw/rtl/tql_datapath.sv */
// Datapath of the Q-learning update block: Q table memory, scan compare,
// two multiply stages, rounding, saturation and configuration registers. Depends on tql_pkg.
`include "tabular_q_learning_update_defines.svh"
module tql_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  tql_pkg::tql_cmd_type               cmd,
   output tql_pkg::tql_status_type            status,
   input  tql_pkg::tql_req_type               req_data,
   input  logic                               csr_we,
   input  logic [tql_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tql_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output tql_pkg::tql_rsp_type               rsp_data
);
   import tql_pkg::*;

   localparam int GPROD_W = GAMMA_W + 1 + Q_W;        // 42
   localparam int GS_W    = GPROD_W - FRAC_W;         // 26
   localparam int DIFF_W  = Q_W + 3;                  // 27
   localparam int APROD_W = ALPHA_W + 1 + DIFF_W;     // 44
   localparam int DELTA_W = APROD_W - FRAC_W;         // 28
   localparam int SUM_W   = DELTA_W + 1;              // 29

   logic [Q_W-1:0] q_mem [NUM_ENTRIES];

   logic [ALPHA_W-1:0]        alpha_ff;
   logic [GAMMA_W-1:0]        gamma_ff;
   logic [ENTRY_W-1:0]        clr_addr_ff;
   logic                      cmp_valid_ff;
   logic [ACT_W-1:0]          cmp_idx_ff;
   logic                      rsp_valid_ff;

   logic [STATE_W-1:0]        ns_ff;
   logic [ENTRY_W-1:0]        slot_ff;
   logic signed [Q_W-1:0]     reward_ff;
   logic signed [Q_W-1:0]     rd_data_ff;
   logic signed [Q_W-1:0]     best_ff, best_in;
   logic [ACT_W-1:0]          greedy_ff, greedy_in;
   logic signed [Q_W-1:0]     cur_ff;
   logic signed [GPROD_W-1:0] gprod_ff;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [APROD_W-1:0] aprod_ff;
   tql_rsp_type               rsp_data_ff;

   logic signed [GPROD_W-1:0] gsum;
   logic signed [GS_W-1:0]    gscaled;
   logic signed [APROD_W-1:0] asum;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   newsum;
   logic signed [Q_W-1:0]     newq;
   logic                      mem_we, mem_re;
   logic [ENTRY_W-1:0]        mem_waddr, mem_raddr;
   logic [Q_W-1:0]            mem_wdata;
   logic [ENTRY_W-1:0]        req_slot;

   assign req_slot = {req_data.state_index[STATE_W-1:0], req_data.action_taken[ACT_W-1:0]};
   assign status.clear_last = (clr_addr_ff == {ENTRY_W{1'b1}});

   // round to nearest, ties up: add half an LSB, then arithmetic shift
   assign gsum    = gprod_ff + GPROD_W'(32'sd32768);
   assign gscaled = gsum[GPROD_W-1:FRAC_W];
   assign diff_in = DIFF_W'(reward_ff) + DIFF_W'(gscaled) - DIFF_W'(cur_ff);
   assign asum    = aprod_ff + APROD_W'(32'sd32768);
   assign delta   = asum[APROD_W-1:FRAC_W];
   assign newsum  = SUM_W'(cur_ff) + SUM_W'(delta);

   always_comb begin
      if (newsum > SUM_W'(Q_MAX)) begin
         newq = Q_MAX;
      end else if (newsum < SUM_W'(Q_MIN)) begin
         newq = Q_MIN;
      end else begin
         newq = newsum[Q_W-1:0];
      end
   end

   // scan compare: the first action always wins, later ones only when strictly greater
   always_comb begin
      best_in   = best_ff;
      greedy_in = greedy_ff;
      if (cmd.load) begin
         best_in   = '0;
         greedy_in = '0;
      end else if (cmp_valid_ff && (cmp_idx_ff == '0 || rd_data_ff > best_ff)) begin
         best_in   = rd_data_ff;
         greedy_in = cmp_idx_ff;
      end
   end

   assign mem_we    = cmd.clear | cmd.update;
   assign mem_waddr = cmd.clear ? clr_addr_ff : slot_ff;
   assign mem_wdata = cmd.clear ? '0 : newq;
   assign mem_re    = cmd.scan_rd | cmd.cur_rd;
   assign mem_raddr = cmd.scan_rd ? {ns_ff, cmd.scan_idx} : slot_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         q_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= q_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         gamma_ff     <= GAMMA_RESET;
         clr_addr_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LEARNING_RATE: alpha_ff <= csr_wdata[ALPHA_W-1:0];
               CSR_DISCOUNT: begin
                  gamma_ff <= (csr_wdata > GAMMA_ONE) ? GAMMA_ONE : csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + ENTRY_W'(1);
         end
         cmp_valid_ff <= cmd.scan_rd;
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ns_ff     <= req_data.next_state_index[STATE_W-1:0];
         slot_ff   <= req_slot;
         reward_ff <= req_data.reward;
      end
      cmp_idx_ff <= cmd.scan_idx;
      best_ff    <= best_in;
      greedy_ff  <= greedy_in;
      if (cmd.gmul) begin
         cur_ff   <= rd_data_ff;
         gprod_ff <= $signed({1'b0, gamma_ff}) * best_ff;
      end
      if (cmd.target) begin
         diff_ff <= diff_in;
      end
      if (cmd.amul) begin
         aprod_ff <= $signed({1'b0, alpha_ff}) * diff_ff;
      end
      if (cmd.update) begin
         rsp_data_ff.greedy_action <= 3'(greedy_ff);
         rsp_data_ff.best_next_q   <= best_ff;
         rsp_data_ff.updated_q     <= newq;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TQL_ASSERT_NEXT(a_best_never_drops, cmp_valid_ff && cmp_idx_ff != '0,
                    best_ff >= $past(best_ff))
   `TQL_ASSERT(a_no_write_collision, cmd.clear, !cmd.update && !cmd.scan_rd)

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tabular_q_learning_update: directed and random transitions,
// each result scored against a Q-table predictor held in the bench. Needs tql_pkg and the RTL.
module tb;
   import tql_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 232;
   localparam int DRAIN_LIMIT  = 200;
   localparam int TIMEOUT_NS   = 20_000_000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   tql_req_type           req_data;
   logic                  rsp_valid;
   tql_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the Q table and the two rate registers
   logic signed [Q_W-1:0] q_shadow [NUM_ENTRIES];
   logic [ALPHA_W-1:0]    alpha_now;
   logic [GAMMA_W-1:0]    gamma_now;

   // Predicted results, oldest first
   tql_rsp_type predicted_updates [$];
   int          error_count;

   // Random episode walk: states stay within a small window so entries get revisited
   logic [7:0] episode_state;
   logic [7:0] region_base;
   logic [7:0] region_mask;

   tabular_q_learning_update u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // round(x / 2^16), halves go towards +infinity (floor of x/2^16 + 1/2)
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // Works out one transaction's result and updates the shadow table.
   // The scan reads the table as it stood before this transaction.
   function automatic tql_rsp_type apply_transition(input tql_req_type t);
      tql_rsp_type res;
      int unsigned row;
      int unsigned slot;
      int unsigned span;
      int unsigned i;
      longint      best;
      longint      target;
      longint      cur;
      longint      sum;
      res  = '0;
      best = 0;
      row  = (int'(t.next_state_index) % NUM_STATES) * NUM_ACTIONS;
      slot = (int'(t.state_index) % NUM_STATES) * NUM_ACTIONS
             + (int'(t.action_taken) % NUM_ACTIONS);
      if (t.terminal) begin
         // no next state: target is the reward alone, greedy and best report 0
         target = longint'(t.reward);
      end else begin
         // count of zero scans action 0 only; above the table width it is clipped
         span = t.next_action_count;
         if (span == 0) span = 1;
         if (span > NUM_ACTIONS) span = NUM_ACTIONS;
         best = longint'(q_shadow[row]);
         for (i = 1; i < span; i++) begin
            // strict greater-than: first index wins a tie
            if (longint'(q_shadow[row + i]) > best) begin
               best              = longint'(q_shadow[row + i]);
               res.greedy_action = 3'(i);
            end
         end
         target = longint'(t.reward) + round_q16(longint'(gamma_now) * best);
      end
      cur = longint'(q_shadow[slot]);
      sum = cur + round_q16(longint'(alpha_now) * (target - cur));
      if (sum > longint'(Q_MAX)) sum = longint'(Q_MAX);
      if (sum < longint'(Q_MIN)) sum = longint'(Q_MIN);
      q_shadow[slot]  = Q_W'(sum);
      res.best_next_q = Q_W'(best);
      res.updated_q   = Q_W'(sum);
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Result scoreboard: every strobe is matched against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : score_updates
      tql_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_updates.size() == 0) begin
            $error("result strobe with no transaction outstanding");
            error_count++;
         end else begin
            want = predicted_updates.pop_front();
            if (rsp_data.greedy_action !== want.greedy_action) begin
               $error("greedy_action: expected %0d, got %0d",
                      want.greedy_action, rsp_data.greedy_action);
               error_count++;
            end
            if (rsp_data.best_next_q !== want.best_next_q) begin
               $error("best_next_q: expected %0d, got %0d",
                      want.best_next_q, rsp_data.best_next_q);
               error_count++;
            end
            if (rsp_data.updated_q !== want.updated_q) begin
               $error("updated_q: expected %0d, got %0d",
                      want.updated_q, rsp_data.updated_q);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver tasks. Each is entered at a falling edge and returns at one.
   // ---------------------------------------------------------------------------

   function automatic tql_req_type make_transition(input logic [7:0] s, input logic [2:0] a,
                                                   input logic signed [Q_W-1:0] r,
                                                   input logic [7:0] ns, input logic [3:0] cnt,
                                                   input logic term);
      tql_req_type t;
      t.state_index       = s;
      t.action_taken      = a;
      t.reward            = r;
      t.next_state_index  = ns;
      t.next_action_count = cnt;
      t.terminal          = term;
      return t;
   endfunction

   // Offers one transaction and holds it until taken. start is left high so
   // a following transaction can go straight out; idle_sender lowers it.
   task automatic send_transition(input tql_req_type t);
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy !== 1'b0);
      predicted_updates.push_back(apply_transition(t));
      @(negedge clock);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      if (cycles == 0) return;
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Holds the sender off until every predicted result has been seen
   task automatic await_updates();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (predicted_updates.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (predicted_updates.size() != 0) begin
         $error("%0d results never arrived", predicted_updates.size());
         error_count++;
         predicted_updates.delete();
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LEARNING_RATE) begin
         alpha_now = value[ALPHA_W-1:0];
      end else begin
         // discount clips at one
         gamma_now = (value > CSR_DATA_W'(GAMMA_ONE)) ? GAMMA_ONE : value[GAMMA_W-1:0];
      end
      @(negedge clock);
   endtask

   // Rates change only with nothing in flight
   task automatic set_rates(input logic [CSR_DATA_W-1:0] alpha_word,
                            input logic [CSR_DATA_W-1:0] gamma_word);
      await_updates();
      write_csr(CSR_LEARNING_RATE, alpha_word);
      write_csr(CSR_DISCOUNT, gamma_word);
   endtask

   // Mostly well-formed episode steps (next state feeds the following step),
   // the rest pure noise across the full width of every field.
   function automatic tql_req_type next_random_transition();
      tql_req_type t;
      if ($urandom_range(0, 4) == 0) begin
         t.state_index       = 8'($urandom);
         t.action_taken      = 3'($urandom);
         t.reward            = 24'($urandom);
         t.next_state_index  = 8'($urandom);
         t.next_action_count = 4'($urandom);
         t.terminal          = 1'($urandom);
         return t;
      end
      t.state_index      = episode_state;
      t.action_taken     = 3'($urandom);
      t.next_state_index = region_base + (8'($urandom) & region_mask);
      if ($urandom_range(0, 9) == 0) t.next_action_count = 4'($urandom);
      else t.next_action_count = 4'($urandom_range(1, NUM_ACTIONS));
      t.terminal = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: t.reward = 24'(int'($urandom_range(0, 16384)) - 8192);
         // coarse steps make equal Q values, and so ties, likely
         5, 6:          t.reward = 24'((int'($urandom_range(0, 8)) - 4) * 4096);
         7:             t.reward = Q_MAX;
         8:             t.reward = Q_MIN;
         default:       t.reward = 24'($urandom);
      endcase
      if (t.terminal) episode_state = region_base + (8'($urandom) & region_mask);
      else episode_state = t.next_state_index;
      return t;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset rates, empty table: field extremes and the scan special cases
   task automatic test_zero_table_defaults();
      send_transition(make_transition(8'd0, 3'd0, 24'sd0, 8'd0, 4'd1, 1'b0));
      send_transition(make_transition(8'd1, 3'd7, Q_MAX, 8'd2, 4'd8, 1'b0));
      // zero action count: only action 0 scanned
      send_transition(make_transition(8'd255, 3'd7, Q_MIN, 8'd255, 4'd0, 1'b0));
      // terminal: next state and count must be ignored
      send_transition(make_transition(8'd4, 3'd3, 24'sd12345, 8'd1, 4'd15, 1'b1));
      // count above the table width, scan finds Q(1,7)
      send_transition(make_transition(8'd3, 3'd2, -24'sd4096, 8'd1, 4'd15, 1'b0));
      // next state is the current one: scan sees the old Q(1,7)
      send_transition(make_transition(8'd1, 3'd7, 24'sd8191, 8'd1, 4'd8, 1'b0));
      await_updates();
   endtask

   // Near-unity alpha copies rewards into the table, building equal maxima
   task automatic test_greedy_ties();
      set_rates(17'h0FFFF, CSR_DATA_W'(GAMMA_ONE));
      send_transition(make_transition(8'd10, 3'd0, 24'sd100, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd10, 3'd1, 24'sd500, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd10, 3'd2, 24'sd500, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd10, 3'd3, 24'sd200, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd11, 3'd0, 24'sd0, 8'd10, 4'd4, 1'b0));
      send_transition(make_transition(8'd11, 3'd1, 24'sd0, 8'd10, 4'd2, 1'b0));
      send_transition(make_transition(8'd11, 3'd2, 24'sd0, 8'd10, 4'd1, 1'b0));
      // all negative: greatest is not action 0
      send_transition(make_transition(8'd12, 3'd0, -24'sd900, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd12, 3'd1, -24'sd300, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd12, 3'd2, -24'sd300, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd13, 3'd5, 24'sd0, 8'd12, 4'd3, 1'b0));
      await_updates();
   endtask

   // Self-referencing updates at full reward push Q past both rails
   task automatic test_saturation();
      send_transition(make_transition(8'd20, 3'd0, Q_MAX, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd20, 3'd0, Q_MAX, 8'd20, 4'd1, 1'b0));
      send_transition(make_transition(8'd22, 3'd0, Q_MIN, 8'd0, 4'd1, 1'b1));
      send_transition(make_transition(8'd22, 3'd0, Q_MIN, 8'd22, 4'd1, 1'b0));
      await_updates();
   endtask

   // Register extremes, including top write bits and discount above one
   task automatic test_rate_extremes();
      // alpha 0 (bit 16 dropped), discount clipped to one
      set_rates(17'h10000, 17'h1FFFF);
      send_transition(make_transition(8'd20, 3'd0, Q_MIN, 8'd20, 4'd1, 1'b0));
      // smallest non-zero alpha, no discount at all
      set_rates(17'h00001, 17'h00000);
      send_transition(make_transition(8'd30, 3'd1, Q_MAX, 8'd20, 4'd8, 1'b0));
      // largest alpha, discount just above one
      set_rates(17'h1FFFF, 17'd65537);
      send_transition(make_transition(8'd31, 3'd2, Q_MIN, 8'd22, 4'd1, 1'b0));
      await_updates();
   endtask

   // Bursts of back-to-back transactions with random gaps, over several rate settings
   task automatic test_random_episodes();
      int phase;
      int sent;
      int burst;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       set_rates(CSR_DATA_W'(ALPHA_RESET), CSR_DATA_W'(GAMMA_RESET));
            1:       set_rates(17'h0FFFF, CSR_DATA_W'(GAMMA_ONE));
            2:       set_rates(17'h00000, CSR_DATA_W'(GAMMA_ONE));
            3:       set_rates(17'h00001, 17'd65535);
            4:       set_rates(17'h08000, 17'h00000);
            default: set_rates(17'($urandom), 17'($urandom_range(0, 70000)));
         endcase
         region_base   = 8'($urandom);
         region_mask   = phase[0] ? 8'h07 : 8'h1F;
         episode_state = region_base;
         sent          = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               send_transition(next_random_transition());
               sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 20));
         end
         await_updates();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------------
   initial begin : run_tests
      int i;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      error_count = 0;
      for (i = 0; i < NUM_ENTRIES; i++) q_shadow[i] = '0;
      alpha_now = ALPHA_RESET;
      gamma_now = GAMMA_RESET;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      // table clearing sweep holds busy high after reset
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);

      test_zero_table_defaults();
      test_greedy_ties();
      test_saturation();
      test_rate_extremes();
      test_random_episodes();

      await_updates();
      // catch any stray strobes
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tql_pkg.sv
hw/rtl/tql_ctrl.sv
hw/rtl/tql_datapath.sv
hw/rtl/tabular_q_learning_update.sv
tb/tb.sv
